### rtl/assert_macros.svh
// Assertion macros shared by the rotation-to-quaternion RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RMQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("rmq assertion failed");

// Check that a condition never holds outside reset.
`define RMQ_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("rmq forbidden condition seen");

`endif

### rtl/rmq_pkg.sv
// Package for the rotation-matrix-to-quaternion block.
// Holds widths, dominant-component codes and the queue item type; no dependencies.
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int ARG_W     = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
	localparam int SA_W      = ARG_W + 1;
	localparam int NUM_W     = 17;
	localparam int RAD_W     = ARG_W + FRAC_BITS;
	localparam int SQ_W      = (RAD_W + 1) / 2;
	localparam int RADP_W    = 2 * SQ_W;
	localparam int REM_W     = SQ_W + 2;
	localparam int DVAL_W    = SQ_W - 1;
	localparam int DIV_W     = NUM_W + 1 + FRAC_BITS;
	localparam int DVS_W     = SQ_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W     = $clog2(FIFO_DEPTH);

	localparam logic [1:0] DOM_W = 2'd0;
	localparam logic [1:0] DOM_X = 2'd1;
	localparam logic [1:0] DOM_Y = 2'd2;
	localparam logic [1:0] DOM_Z = 2'd3;

	typedef struct packed {
		logic                    bad;
		logic [1:0]              dom;
		logic [ARG_W-1:0]        arg;
		logic signed [NUM_W-1:0] na;
		logic signed [NUM_W-1:0] nb;
		logic signed [NUM_W-1:0] nc;
	} item_t;

endpackage

### rtl/rotation_matrix_to_quaternion.sv
// Top level of the rotation-matrix-to-quaternion block (Shoemake's method).
// Uses rmq_pkg, rmq_front, rmq_fifo and rmq_back.
//
// One 3x3 matrix of signed Q2.14 entries enters per request and leaves as the
// quaternion (w, x, y, z) in the same format, saturated, with tuser set and all
// components zero when the square-root argument is not positive. The block
// takes one request per clock cycle while the queue has room. Each result
// passes through the queue, the bit-per-stage square-root pipeline
// (16 stages), one operand stage and the bit-per-stage dividers (32 stages),
// whose last stage loads the output register. A four-entry queue separates the
// classifying front end from the arithmetic pipeline, which halts as a whole
// while a result waits; every such cycle adds to the latency.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// quat_w, quat_x, quat_y, quat_z, 16 bits each
	output logic [63:0]  m_axis_tdata,
	// bad_input
	output logic         m_axis_tuser
);

	item_t front_item;
	item_t queue_item;
	logic  queue_valid;
	logic  back_ready;

	rmq_front u_front (
		.m00(s_axis_tdata[15:0]),    .m01(s_axis_tdata[31:16]),
		.m02(s_axis_tdata[47:32]),   .m10(s_axis_tdata[63:48]),
		.m11(s_axis_tdata[79:64]),   .m12(s_axis_tdata[95:80]),
		.m20(s_axis_tdata[111:96]),  .m21(s_axis_tdata[127:112]),
		.m22(s_axis_tdata[143:128]), .item(front_item)
	);

	rmq_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(s_axis_tvalid), .not_full(s_axis_tready), .wr_item(front_item),
		.not_empty(queue_valid), .pop(back_ready), .rd_item(queue_item)
	);

	rmq_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(queue_valid), .in_ready(back_ready), .in_item(queue_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_user(m_axis_tuser)
	);

endmodule

### rtl/rmq_front.sv
// Front end: classifies one matrix, picks the dominant component,
// forms the square-root argument and the three numerators. Uses rmq_pkg.
module rmq_front import rmq_pkg::*; (
	input  logic signed [15:0] m00,
	input  logic signed [15:0] m01,
	input  logic signed [15:0] m02,
	input  logic signed [15:0] m10,
	input  logic signed [15:0] m11,
	input  logic signed [15:0] m12,
	input  logic signed [15:0] m20,
	input  logic signed [15:0] m21,
	input  logic signed [15:0] m22,
	output item_t              item
);

	function automatic logic signed [NUM_W-1:0] sub_n(logic signed [15:0] a,
			logic signed [15:0] b);
		return NUM_W'(a) - NUM_W'(b);
	endfunction

	function automatic logic signed [NUM_W-1:0] add_n(logic signed [15:0] a,
			logic signed [15:0] b);
		return NUM_W'(a) + NUM_W'(b);
	endfunction

	function automatic logic signed [SA_W-1:0] arg_of(logic signed [15:0] a,
			logic signed [15:0] b, logic signed [15:0] c);
		return SA_W'(a) - SA_W'(b) - SA_W'(c) + SA_W'(ONE);
	endfunction

	logic signed [17:0]     tr;
	logic signed [SA_W-1:0] arg_x;
	logic [1:0]             dom;

	always_comb begin
		tr = 18'(m00) + 18'(m11) + 18'(m22);
		dom = DOM_X;
		if (m11 > m00) dom = DOM_Y;
		if (m22 > ((dom == DOM_Y) ? m11 : m00)) dom = DOM_Z;
		if (tr > 0) dom = DOM_W;
		case (dom)
			DOM_W: begin
				arg_x = SA_W'(tr) + SA_W'(ONE);
				item.na = sub_n(m21, m12);
				item.nb = sub_n(m02, m20);
				item.nc = sub_n(m10, m01);
			end
			DOM_X: begin
				arg_x = arg_of(m00, m11, m22);
				item.na = sub_n(m21, m12);
				item.nb = add_n(m10, m01);
				item.nc = add_n(m20, m02);
			end
			DOM_Y: begin
				arg_x = arg_of(m11, m22, m00);
				item.na = sub_n(m02, m20);
				item.nb = add_n(m21, m12);
				item.nc = add_n(m01, m10);
			end
			default: begin
				arg_x = arg_of(m22, m00, m11);
				item.na = sub_n(m10, m01);
				item.nb = add_n(m02, m20);
				item.nc = add_n(m12, m21);
			end
		endcase
		item.dom = dom;
		item.bad = (arg_x <= 0);
		item.arg = item.bad ? '0 : arg_x[ARG_W-1:0];
	end

endmodule

### rtl/rmq_fifo.sv
// Short queue between front and back ends.
// Register-based, FIFO_DEPTH entries of item_t. Uses rmq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rmq_fifo import rmq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  not_full,
	input  item_t wr_item,
	output logic  not_empty,
	input  logic  pop,
	output item_t rd_item
);

	item_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != (PTR_W+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= PTR_W'((wr_ptr_q + 1'b1) % FIFO_DEPTH);
			if (do_pop) rd_ptr_q <= PTR_W'((rd_ptr_q + 1'b1) % FIFO_DEPTH);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	`RMQ_NEVER(a_count_range, count_q > (PTR_W+1)'(FIFO_DEPTH))
	`RMQ_ASSERT(a_count_track, do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)

endmodule

### rtl/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage, DIV_W stages.
// Advances on en. Uses rmq_pkg.
module rmq_div import rmq_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] dd_s  [DIV_W];
	logic [DVS_W-1:0] dv_s  [DIV_W];
	logic [DVS_W-1:0] rem_s [DIV_W];
	logic [DIV_W-1:0] q_s   [DIV_W];

	logic [DIV_W-1:0] dd_i  [DIV_W];
	logic [DVS_W-1:0] dv_i  [DIV_W];
	logic [DVS_W-1:0] rem_i [DIV_W];
	logic [DIV_W-1:0] q_i   [DIV_W];
	logic [DVS_W:0]   pre   [DIV_W];

	always_comb begin
		dd_i[0]  = dividend;
		dv_i[0]  = divisor;
		rem_i[0] = '0;
		q_i[0]   = '0;
		for (int t = 1; t < DIV_W; t++) begin
			dd_i[t]  = dd_s[t-1];
			dv_i[t]  = dv_s[t-1];
			rem_i[t] = rem_s[t-1];
			q_i[t]   = q_s[t-1];
		end
		for (int t = 0; t < DIV_W; t++) pre[t] = {rem_i[t], dd_i[t][DIV_W-1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < DIV_W; t++) begin
				dd_s[t] <= {dd_i[t][DIV_W-2:0], 1'b0};
				dv_s[t] <= dv_i[t];
				if (pre[t] >= {1'b0, dv_i[t]}) begin
					rem_s[t] <= DVS_W'(pre[t] - {1'b0, dv_i[t]});
					q_s[t]   <= {q_i[t][DIV_W-2:0], 1'b1};
				end else begin
					rem_s[t] <= pre[t][DVS_W-1:0];
					q_s[t]   <= {q_i[t][DIV_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quotient = q_s[DIV_W-1];

endmodule

### rtl/rmq_back.sv
// Back end: pipelined square root, three pipelined dividers, saturation
// and the output register. Uses rmq_pkg, rmq_div and assert_macros.svh.
`include "assert_macros.svh"
module rmq_back import rmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_data,
	output logic        out_user
);

	typedef struct packed {
		logic                    bad;
		logic [1:0]              dom;
		logic signed [NUM_W-1:0] na;
		logic signed [NUM_W-1:0] nb;
		logic signed [NUM_W-1:0] nc;
	} sq_sb_t;

	typedef struct packed {
		logic              bad;
		logic [1:0]        dom;
		logic              nega;
		logic              negb;
		logic              negc;
		logic [DVAL_W-1:0] dval;
	} dv_sb_t;

	logic adv;
	logic take;

	logic [SQ_W-1:0]   sq_v_s;
	logic [RADP_W-1:0] sq_rad_s  [SQ_W];
	logic [REM_W-1:0]  sq_rem_s  [SQ_W];
	logic [SQ_W-1:0]   sq_root_s [SQ_W];
	sq_sb_t            sq_sb_s   [SQ_W];

	logic [RADP_W-1:0] rad_i  [SQ_W];
	logic [REM_W-1:0]  rem_i  [SQ_W];
	logic [SQ_W-1:0]   root_i [SQ_W];
	sq_sb_t            sb_i   [SQ_W];
	logic [REM_W+1:0]  pre    [SQ_W];
	logic [REM_W+1:0]  trial  [SQ_W];

	logic             pre_v_s;
	dv_sb_t           pre_sb_s;
	logic [DIV_W-1:0] pre_da_s;
	logic [DIV_W-1:0] pre_db_s;
	logic [DIV_W-1:0] pre_dc_s;
	logic [DVS_W-1:0] pre_dv_s;

	logic [DIV_W-1:0] dv_v_s;
	dv_sb_t           dv_sb_s [DIV_W];
	logic [DIV_W-1:0] qa;
	logic [DIV_W-1:0] qb;
	logic [DIV_W-1:0] qc;

	logic        out_v_q;
	logic [63:0] out_data_q;
	logic        out_user_q;

	logic [SQ_W-1:0]  root_l;
	sq_sb_t           sb_l;
	logic [15:0]      ra;
	logic [15:0]      rb;
	logic [15:0]      rc;
	logic [15:0]      rd;
	logic [63:0]      res;

	assign adv      = !out_v_q || out_ready;
	assign in_ready = adv;
	assign take     = in_valid && adv;

	function automatic logic [DIV_W-1:0] mag_of(logic signed [NUM_W-1:0] n,
			logic [SQ_W-1:0] s);
		logic [NUM_W-1:0] a;
		a = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
		return ({{(DIV_W-NUM_W-FRAC_BITS){1'b0}}, a, {FRAC_BITS{1'b0}}})
			+ DIV_W'(s);
	endfunction

	function automatic logic [15:0] sat_q(logic neg, logic [DIV_W-1:0] q);
		if (!neg) return (q > DIV_W'(32767)) ? 16'h7fff : q[15:0];
		return (q > DIV_W'(32768)) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
	endfunction

	// square root stages
	always_comb begin
		rad_i[0]  = RADP_W'({in_item.arg, {FRAC_BITS{1'b0}}});
		rem_i[0]  = '0;
		root_i[0] = '0;
		sb_i[0]   = '{bad: in_item.bad, dom: in_item.dom, na: in_item.na,
			nb: in_item.nb, nc: in_item.nc};
		for (int t = 1; t < SQ_W; t++) begin
			rad_i[t]  = sq_rad_s[t-1];
			rem_i[t]  = sq_rem_s[t-1];
			root_i[t] = sq_root_s[t-1];
			sb_i[t]   = sq_sb_s[t-1];
		end
		for (int t = 0; t < SQ_W; t++) begin
			pre[t]   = {rem_i[t], rad_i[t][RADP_W-1 -: 2]};
			trial[t] = {2'b00, root_i[t], 2'b01};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < SQ_W; t++) begin
				sq_rad_s[t] <= {rad_i[t][RADP_W-3:0], 2'b00};
				sq_sb_s[t]  <= sb_i[t];
				if (pre[t] >= trial[t]) begin
					sq_rem_s[t]  <= REM_W'(pre[t] - trial[t]);
					sq_root_s[t] <= {root_i[t][SQ_W-2:0], 1'b1};
				end else begin
					sq_rem_s[t]  <= pre[t][REM_W-1:0];
					sq_root_s[t] <= {root_i[t][SQ_W-2:0], 1'b0};
				end
			end
		end
	end

	// divider operand preparation
	assign root_l = sq_root_s[SQ_W-1];
	assign sb_l   = sq_sb_s[SQ_W-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_sb_s <= '{bad: sb_l.bad, dom: sb_l.dom, nega: sb_l.na[NUM_W-1],
				negb: sb_l.nb[NUM_W-1], negc: sb_l.nc[NUM_W-1],
				dval: root_l[SQ_W-1:1]};
			pre_da_s <= mag_of(sb_l.na, root_l);
			pre_db_s <= mag_of(sb_l.nb, root_l);
			pre_dc_s <= mag_of(sb_l.nc, root_l);
			pre_dv_s <= {root_l, 1'b0};
			dv_sb_s[0] <= pre_sb_s;
			for (int t = 1; t < DIV_W; t++) dv_sb_s[t] <= dv_sb_s[t-1];
		end
	end

	rmq_div u_div_a (.clk(clk), .en(adv), .dividend(pre_da_s), .divisor(pre_dv_s),
		.quotient(qa));
	rmq_div u_div_b (.clk(clk), .en(adv), .dividend(pre_db_s), .divisor(pre_dv_s),
		.quotient(qb));
	rmq_div u_div_c (.clk(clk), .en(adv), .dividend(pre_dc_s), .divisor(pre_dv_s),
		.quotient(qc));

	// saturate and place components
	always_comb begin
		ra = sat_q(dv_sb_s[DIV_W-1].nega, qa);
		rb = sat_q(dv_sb_s[DIV_W-1].negb, qb);
		rc = sat_q(dv_sb_s[DIV_W-1].negc, qc);
		rd = ({16'd0, dv_sb_s[DIV_W-1].dval} > (DVAL_W+16)'(32767)) ? 16'h7fff
			: 16'(dv_sb_s[DIV_W-1].dval);
		case (dv_sb_s[DIV_W-1].dom)
			DOM_W:   res = {rc, rb, ra, rd};
			DOM_X:   res = {rc, rb, rd, ra};
			DOM_Y:   res = {rb, rd, rc, ra};
			default: res = {rd, rc, rb, ra};
		endcase
		if (dv_sb_s[DIV_W-1].bad) res = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
			out_user_q <= dv_sb_s[DIV_W-1].bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s  <= '0;
			pre_v_s <= 1'b0;
			dv_v_s  <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			sq_v_s  <= {sq_v_s[SQ_W-2:0], take};
			pre_v_s <= sq_v_s[SQ_W-1];
			dv_v_s  <= {dv_v_s[DIV_W-2:0], pre_v_s};
			out_v_q <= dv_v_s[DIV_W-1];
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	`RMQ_ASSERT(a_bad_zero, out_v_q && out_user_q |-> out_data_q == '0)

endmodule

### dv/rmq_checker.sv
// Checker for the rotation-matrix-to-quaternion block: watches both stream channels,
// predicts each quaternion from the accepted matrix and compares field by field.
// Depends on nothing but the ports of the block.
module rmq_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,
	input  logic         m_axis_tuser,
	output int           fail_count,
	output int           pending
);
	localparam int FB = 14;

	typedef struct packed {
		logic        bad;
		logic [15:0] qz;
		logic [15:0] qy;
		logic [15:0] qx;
		logic [15:0] qw;
	} quat_t;

	quat_t expected_quats[$];

	function automatic longint int_sqrt(longint n);
		longint res;
		longint b;
		res = 0;
		b = 64'sd1 <<< 60;
		while (b > n)
			b = b >>> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - res - b;
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	function automatic longint round_div(longint num, longint s);
		longint p;
		longint mag;
		longint q;
		p = num <<< FB;
		mag = (p < 0) ? -p : p;
		q = (mag + s) / (2 * s);
		return (p < 0) ? -q : q;
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic quat_t matrix_to_quat(logic [143:0] d);
		longint m[3][3];
		longint q[4];
		longint tr;
		longint a;
		longint s;
		int i;
		int j;
		int k;
		quat_t r;
		for (int n = 0; n < 9; n++)
			m[n / 3][n % 3] = longint'($signed(d[16*n +: 16]));
		tr = m[0][0] + m[1][1] + m[2][2];
		r = '0;
		if (tr > 0) begin
			s = int_sqrt((tr + (1 << FB)) <<< FB);
			if (s == 0) begin
				r.bad = 1'b1;
				return r;
			end
			q[0] = s >>> 1;
			q[1] = round_div(m[2][1] - m[1][2], s);
			q[2] = round_div(m[0][2] - m[2][0], s);
			q[3] = round_div(m[1][0] - m[0][1], s);
		end else begin
			i = 0;
			if (m[1][1] > m[0][0])
				i = 1;
			if (m[2][2] > m[i][i])
				i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			a = m[i][i] - m[j][j] - m[k][k] + (1 << FB);
			if (a <= 0) begin
				r.bad = 1'b1;
				return r;
			end
			s = int_sqrt(a <<< FB);
			if (s == 0) begin
				r.bad = 1'b1;
				return r;
			end
			q[i + 1] = s >>> 1;
			q[0] = round_div(m[k][j] - m[j][k], s);
			q[j + 1] = round_div(m[j][i] + m[i][j], s);
			q[k + 1] = round_div(m[k][i] + m[i][k], s);
		end
		r.qw = clamp16(q[0]);
		r.qx = clamp16(q[1]);
		r.qy = clamp16(q[2]);
		r.qz = clamp16(q[3]);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
		fail_count++;
	endtask

	initial fail_count = 0;
	initial pending = 0;

	always @(posedge clk) begin
		quat_t exp_q;
		quat_t got_q;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_quats.push_back(matrix_to_quat(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got_q = {m_axis_tuser, m_axis_tdata};
				if (expected_quats.size() == 0) begin
					$display("mismatch: result with nothing outstanding");
					fail_count++;
				end else begin
					exp_q = expected_quats.pop_front();
					if (got_q.qw !== exp_q.qw)
						report_mismatch("quat_w", got_q.qw, exp_q.qw);
					if (got_q.qx !== exp_q.qx)
						report_mismatch("quat_x", got_q.qx, exp_q.qx);
					if (got_q.qy !== exp_q.qy)
						report_mismatch("quat_y", got_q.qy, exp_q.qy);
					if (got_q.qz !== exp_q.qz)
						report_mismatch("quat_z", got_q.qz, exp_q.qz);
					if (got_q.bad !== exp_q.bad)
						report_mismatch("bad_input", 16'(got_q.bad), 16'(exp_q.bad));
				end
			end
		end
		pending = expected_quats.size();
	end
endmodule

### dv/rotation_matrix_to_quaternion_tb.sv
// Testbench top for the rotation-matrix-to-quaternion block: drives directed and random
// matrices with random gaps and stalls, and gives the verdict from rmq_checker.
// Depends on rotation_matrix_to_quaternion and rmq_checker.
module rotation_matrix_to_quaternion_tb;
	localparam int N_RANDOM = 800;
	localparam int ONE_Q = 1 << 14;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tuser;
	int           fail_count;
	int           pending;
	logic         hold_sink = 1'b0;

	rotation_matrix_to_quaternion dut (.*);

	rmq_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [143:0] pack_matrix(int e[9]);
		logic [143:0] d;
		for (int n = 0; n < 9; n++)
			d[16*n +: 16] = e[n][15:0];
		return d;
	endfunction

	function automatic int pick_entry();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return $urandom_range(0, 2 * ONE_Q) - ONE_Q;
			3: return ONE_Q;
			4: return 0;
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	function automatic logic [143:0] random_matrix();
		int e[9];
		real a;
		real b;
		real c;
		real d;
		real nrm;
		real r[9];
		if ($urandom_range(0, 3) == 0) begin
			for (int n = 0; n < 9; n++)
				e[n] = pick_entry();
			return pack_matrix(e);
		end
		a = real'($urandom_range(0, 2000)) - 1000.0;
		b = real'($urandom_range(0, 2000)) - 1000.0;
		c = real'($urandom_range(0, 2000)) - 1000.0;
		d = real'($urandom_range(0, 2000)) - 1000.0;
		nrm = a * a + b * b + c * c + d * d;
		if (nrm < 1.0) begin
			a = 1.0;
			nrm = 1.0;
		end
		r[0] = 1.0 - 2.0 * (c * c + d * d) / nrm;
		r[1] = 2.0 * (b * c - a * d) / nrm;
		r[2] = 2.0 * (b * d + a * c) / nrm;
		r[3] = 2.0 * (b * c + a * d) / nrm;
		r[4] = 1.0 - 2.0 * (b * b + d * d) / nrm;
		r[5] = 2.0 * (c * d - a * b) / nrm;
		r[6] = 2.0 * (b * d - a * c) / nrm;
		r[7] = 2.0 * (c * d + a * b) / nrm;
		r[8] = 1.0 - 2.0 * (b * b + c * c) / nrm;
		for (int n = 0; n < 9; n++)
			e[n] = $rtoi(r[n] * ONE_Q) + $urandom_range(0, 4) - 2;
		return pack_matrix(e);
	endfunction

	task automatic send_matrix(logic [143:0] d, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_directed();
		int e[9];
		int cases[][9] = '{
			'{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q},
			'{ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q},
			'{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q},
			'{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q},
			'{0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q},
			'{0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q},
			'{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768},
			'{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767},
			'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
			'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
			'{-100, 5, 7, 9, -100, 11, 13, 15, -100},
			'{0, 1, 2, 3, 0, 4, 5, 6, 0},
			'{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, -1},
			'{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q},
			'{ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q},
			'{-32768, 0, 0, 0, 32767, 0, 0, 0, -32768}
		};
		foreach (cases[c]) begin
			for (int n = 0; n < 9; n++)
				e[n] = cases[c][n];
			send_matrix(pack_matrix(e), 1'b0);
		end
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 300) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			if (n == 500)
				hold_sink <= 1'b1;
			send_matrix(random_matrix(), (n % 200) > 40);
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				repeat (300)
					@(posedge clk);
				hold_sink = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 4) == 0)
				stall = 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall)
					@(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

### files.f
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_fifo.sv
rtl/rmq_div.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
dv/rmq_checker.sv
dv/rotation_matrix_to_quaternion_tb.sv
